@@ rtl/mip_off_pkg.sv @@
package mip_off_pkg;

   localparam int MAX_LEVELS = 15;
   localparam int MAX_IMAGES = 2048;
   localparam int LANES      = 16;
   localparam int PIPE_STAGES = 9;

   localparam int DIM_W   = 15;
   localparam int BLK_W   = 14;
   localparam int CNT_W   = 2 * BLK_W - 1;
   localparam int BSZ_W   = 7;
   localparam int SIZE_W  = 33;
   localparam int SUM_W   = 34;
   localparam int IMG_W   = 11;
   localparam int PROD_W  = IMG_W + SUM_W;
   localparam int OFF_W   = 48;
   localparam int BYTES_W = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVELS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGES = 3'd4;

   localparam logic [3:0] FMT_DXT1 = 4'd0;
   localparam logic [3:0] FMT_DXT3 = 4'd1;
   localparam logic [3:0] FMT_DXT5 = 4'd2;
   localparam logic [3:0] FMT_ATI1 = 4'd3;
   localparam logic [3:0] FMT_ATI2 = 4'd4;
   localparam logic [3:0] FMT_BGR  = 4'd5;
   localparam logic [3:0] FMT_BGRA = 4'd6;
   localparam logic [3:0] FMT_BPTC_A = 4'd7;
   localparam logic [3:0] FMT_BPTC_B = 4'd8;

   typedef struct packed {
      logic [3:0]       level_index;
      logic [IMG_W-1:0] image_select;
   } req_payload_type;

   typedef struct packed {
      logic [OFF_W-1:0]   byte_offset;
      logic [BYTES_W-1:0] byte_size;
      logic [DIM_W-1:0]   level_width;
      logic [DIM_W-1:0]   level_height;
      logic               index_error;
   } rsp_payload_type;

   function automatic logic [BSZ_W-1:0] block_bytes(input logic [3:0] fmt);
      logic [BSZ_W-1:0] b;
      case (fmt) inside
         FMT_DXT1, FMT_ATI1:                       b = 7'd8;
         FMT_DXT3, FMT_DXT5, FMT_ATI2,
         FMT_BPTC_A, FMT_BPTC_B:                   b = 7'd16;
         FMT_BGR:                                  b = 7'd48;
         FMT_BGRA:                                 b = 7'd64;
         default:                                  b = 7'd0;
      endcase
      return b;
   endfunction

endpackage

@@ rtl/mip_level_offset_calculator.sv @@
// Mip level offset calculator for a packed texture store.
// The csr channel writes the format code, base width and height, mip level
// count and image count; csr_ready is always high. The user must write
// configuration only while no request beat is in flight; the block does not enforce it.
// Each req beat names a mip level and an image. Exactly one rsp beat follows,
// in request order, carrying the byte offset of that level from the start of
// the store, its byte size (saturated at 2^31-1), its pixel dimensions and an
// index error flag; on an index error all other fields are zero.
// The pipeline has nine register stages: the range check and block dimensions,
// a multiplier per level for the block counts, the block size scaling, a
// four-level registered adder tree over the levels, the image multiply and the
// final add. One beat is taken every cycle while the receiver keeps rsp_ready high.
// When the receiver stalls, each stage holds and bubbles are squeezed out;
// req_ready falls only once every stage holds a beat.
// Reset clears all stage valid bits and sets the configuration to format 0,
// a 1 x 1 base, one level and one image.
module mip_level_offset_calculator
   import mip_off_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   typedef struct packed {
      logic             err;
      logic [3:0]       lvl;
      logic [IMG_W-1:0] img;
      logic [DIM_W-1:0] lw;
      logic [DIM_W-1:0] lh;
   } side_type;

   logic [3:0]       format_ff;
   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;
   logic [3:0]       levels_ff;
   logic [11:0]      images_ff;

   logic [PIPE_STAGES-1:0] v_ff;
   logic [PIPE_STAGES-1:0] en;
   side_type               side_ff [PIPE_STAGES];
   side_type               side_in;

   logic [4:0]       nlev;
   logic [12:0]      nimg;
   logic [DIM_W-1:0] w_lane [LANES];
   logic [DIM_W-1:0] h_lane [LANES];

   logic [BLK_W-1:0]  bw_ff [LANES];
   logic [BLK_W-1:0]  bh_ff [LANES];
   logic [BLK_W-1:0]  bw_in [LANES];
   logic [BLK_W-1:0]  bh_in [LANES];
   logic [LANES-1:0]  tmask1_ff, pmask1_ff, tmask_in, pmask_in;

   logic [CNT_W-1:0]  cnt_ff [LANES];
   logic [LANES-1:0]  tmask2_ff, pmask2_ff;

   logic [CNT_W+BSZ_W-1:0] prod3 [LANES];
   logic [BSZ_W-1:0]  bsz;
   logic [SIZE_W-1:0] size_ff [LANES];
   logic [LANES-1:0]  tmask3_ff, pmask3_ff;

   logic [SUM_W-1:0]  tot4_ff [LANES/2];
   logic [SUM_W-1:0]  pre4_ff [LANES/2];
   logic [SUM_W-1:0]  tot4_in [LANES/2];
   logic [SUM_W-1:0]  pre4_in [LANES/2];
   logic [SUM_W-1:0]  tot5_ff [LANES/4];
   logic [SUM_W-1:0]  pre5_ff [LANES/4];
   logic [SUM_W-1:0]  tot6_ff [LANES/8];
   logic [SUM_W-1:0]  pre6_ff [LANES/8];
   logic [SUM_W-1:0]  tot7_ff, pre7_ff, pre8_ff;
   logic [SIZE_W-1:0] sel4_ff, sel5_ff, sel6_ff, sel7_ff, sel8_ff;
   logic [PROD_W-1:0] base8_ff, base8_in;

   rsp_payload_type   rsp_ff, rsp_in;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= 4'd0;
         width_ff  <= DIM_W'(1);
         height_ff <= DIM_W'(1);
         levels_ff <= 4'd1;
         images_ff <= 12'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FORMAT: format_ff <= csr_data[3:0];
            CSR_WIDTH:  width_ff  <= csr_data[DIM_W-1:0];
            CSR_HEIGHT: height_ff <= csr_data[DIM_W-1:0];
            CSR_LEVELS: levels_ff <= csr_data[3:0];
            CSR_IMAGES: images_ff <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   // Stage flow control: a stage loads when it is empty or its beat moves on.
   always_comb begin
      en[PIPE_STAGES-1] = !v_ff[PIPE_STAGES-1] || rsp_ready;
      for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < PIPE_STAGES; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         side_ff[0] <= side_in;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
         if (en[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Stage 1: range check, per-level dimensions and block dimensions.
   always_comb begin
      if (levels_ff == 4'd0) begin
         nlev = 5'd1;
      end else if ({1'b0, levels_ff} > 5'(MAX_LEVELS)) begin
         nlev = 5'(MAX_LEVELS);
      end else begin
         nlev = {1'b0, levels_ff};
      end
      nimg = ({1'b0, images_ff} > 13'(MAX_IMAGES)) ? 13'(MAX_IMAGES) : {1'b0, images_ff};

      for (int i = 0; i < LANES; i++) begin
         if (i == 0) begin
            w_lane[i] = width_ff;
            h_lane[i] = height_ff;
         end else begin
            w_lane[i] = ((width_ff >> i) == '0) ? DIM_W'(1) : (width_ff >> i);
            h_lane[i] = ((height_ff >> i) == '0) ? DIM_W'(1) : (height_ff >> i);
         end
         bw_in[i]    = BLK_W'(({1'b0, w_lane[i]} + 16'd3) >> 2);
         bh_in[i]    = BLK_W'(({1'b0, h_lane[i]} + 16'd3) >> 2);
         tmask_in[i] = 5'(i) < nlev;
         pmask_in[i] = 5'(i) < {1'b0, req_payload.level_index};
      end

      side_in.lvl = req_payload.level_index;
      side_in.img = req_payload.image_select;
      side_in.err = ({1'b0, req_payload.level_index} >= nlev) ||
                    ({2'b00, req_payload.image_select} >= nimg);
      side_in.lw  = w_lane[req_payload.level_index];
      side_in.lh  = h_lane[req_payload.level_index];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         bw_ff     <= bw_in;
         bh_ff     <= bh_in;
         tmask1_ff <= tmask_in;
         pmask1_ff <= pmask_in;
      end
   end

   // Stage 2: block count of every level.
   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int i = 0; i < LANES; i++) begin
            cnt_ff[i] <= CNT_W'(bw_ff[i]) * CNT_W'(bh_ff[i]);
         end
         tmask2_ff <= tmask1_ff;
         pmask2_ff <= pmask1_ff;
      end
   end

   // Stage 3: byte size of every level.
   assign bsz = block_bytes(format_ff);

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         prod3[i] = cnt_ff[i] * bsz;
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int i = 0; i < LANES; i++) begin
            size_ff[i] <= prod3[i][SIZE_W-1:0];
         end
         tmask3_ff <= tmask2_ff;
         pmask3_ff <= pmask2_ff;
      end
   end

   // Stages 4 to 7: adder tree for the image total and the level prefix.
   always_comb begin
      for (int j = 0; j < LANES / 2; j++) begin
         tot4_in[j] = (tmask3_ff[2*j]   ? SUM_W'(size_ff[2*j])   : '0) +
                      (tmask3_ff[2*j+1] ? SUM_W'(size_ff[2*j+1]) : '0);
         pre4_in[j] = (pmask3_ff[2*j]   ? SUM_W'(size_ff[2*j])   : '0) +
                      (pmask3_ff[2*j+1] ? SUM_W'(size_ff[2*j+1]) : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         tot4_ff <= tot4_in;
         pre4_ff <= pre4_in;
         sel4_ff <= size_ff[side_ff[2].lvl];
      end
      if (en[4]) begin
         for (int j = 0; j < LANES / 4; j++) begin
            tot5_ff[j] <= tot4_ff[2*j] + tot4_ff[2*j+1];
            pre5_ff[j] <= pre4_ff[2*j] + pre4_ff[2*j+1];
         end
         sel5_ff <= sel4_ff;
      end
      if (en[5]) begin
         for (int j = 0; j < LANES / 8; j++) begin
            tot6_ff[j] <= tot5_ff[2*j] + tot5_ff[2*j+1];
            pre6_ff[j] <= pre5_ff[2*j] + pre5_ff[2*j+1];
         end
         sel6_ff <= sel5_ff;
      end
      if (en[6]) begin
         tot7_ff <= tot6_ff[0] + tot6_ff[1];
         pre7_ff <= pre6_ff[0] + pre6_ff[1];
         sel7_ff <= sel6_ff;
      end
   end

   // Stage 8: start of the requested image.
   assign base8_in = side_ff[6].img * tot7_ff;

   always_ff @(posedge clock) begin
      if (en[7]) begin
         base8_ff <= base8_in;
         pre8_ff  <= pre7_ff;
         sel8_ff  <= sel7_ff;
      end
   end

   // Stage 9: final offset, size saturation and error zeroing.
   always_comb begin
      rsp_in.index_error = side_ff[7].err;
      if (side_ff[7].err) begin
         rsp_in.byte_offset  = '0;
         rsp_in.byte_size    = '0;
         rsp_in.level_width  = '0;
         rsp_in.level_height = '0;
      end else begin
         rsp_in.byte_offset  = OFF_W'(base8_ff) + OFF_W'(pre8_ff);
         rsp_in.byte_size    = (sel8_ff > SIZE_W'({BYTES_W{1'b1}})) ? {BYTES_W{1'b1}}
                                                                   : sel8_ff[BYTES_W-1:0];
         rsp_in.level_width  = side_ff[7].lw;
         rsp_in.level_height = side_ff[7].lh;
      end
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = v_ff[PIPE_STAGES-1];
   assign rsp_payload = rsp_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.index_error |->
         rsp_payload.byte_offset == '0 && rsp_payload.byte_size == '0 &&
         rsp_payload.level_width == '0 && rsp_payload.level_height == '0)
      else $error("index error result carries nonzero fields");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> &v_ff)
      else $error("request stalled while a pipeline stage is empty");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_keeps_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !en[PIPE_STAGES-1])
      else $error("output stage enabled while its beat waits");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import mip_off_pkg::*;

   localparam logic [3:0] FMT_UNKNOWN_FIRST = 4'd9;
   localparam logic [3:0] FMT_UNKNOWN_LAST  = 4'd15;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_UNUSED  = 3'd7;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int RANDOM_PHASES = 12;
   localparam int ITEMS_PER_PHASE = 36;
   localparam int PROBE_COUNT = 24;

   typedef struct packed {
      logic [3:0]  fmt;
      logic [14:0] width;
      logic [14:0] height;
      logic [3:0]  levels;
      logic [11:0] images;
   } store_cfg_type;

   typedef struct packed {
      store_cfg_type    cfg;
      logic [3:0]       level;
      logic [IMG_W-1:0] image;
      logic             known;
      rsp_payload_type  want;
   } probe_row_type;

   localparam rsp_payload_type ZERO_RSP  = {48'd0, 31'd0, 15'd0, 15'd0, 1'b0};
   localparam rsp_payload_type FAULT_RSP = {48'd0, 31'd0, 15'd0, 15'd0, 1'b1};
   localparam store_cfg_type RESET_CFG = {FMT_DXT1, 15'd1, 15'd1, 4'd1, 12'd1};
   localparam store_cfg_type HUGE_RGBA = {FMT_BGRA, 15'd16384, 15'd16384, 4'd15, 12'd2048};
   localparam store_cfg_type OVER_RGB  = {FMT_BGR, 15'd32767, 15'd32767, 4'd15, 12'd4095};
   localparam store_cfg_type EMPTY_ONE = {FMT_DXT1, 15'd0, 15'd0, 4'd0, 12'd5};
   localparam store_cfg_type EMPTY_MIP = {FMT_DXT1, 15'd0, 15'd0, 4'd3, 12'd5};

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   store_cfg_type   store_regs = RESET_CFG;
   rsp_payload_type expected_levels[$];
   bit              req_idle_on = 1'b1;
   bit              rsp_idle_on = 1'b1;
   bit              hold_off_armed = 1'b0;
   logic            hold_rsp = 1'b0;
   int              rsp_gap_left = 0;
   int              rsp_gap_draw;
   int              mismatches = 0;
   int              results_seen = 0;
   int              requests_sent = 0;
   int              index_faults = 0;
   int              saturated_sizes = 0;
   int              settings_used = 0;
   int              stalled_cycles = 0;

   probe_row_type probes [PROBE_COUNT] = '{
      {RESET_CFG, 4'd0, 11'd0, 1'b1, {48'd0, 31'd8, 15'd1, 15'd1, 1'b0}},
      {RESET_CFG, 4'd1, 11'd0, 1'b1, FAULT_RSP},
      {RESET_CFG, 4'd0, 11'd1, 1'b1, FAULT_RSP},
      {RESET_CFG, 4'd15, 11'd2047, 1'b1, FAULT_RSP},
      {HUGE_RGBA, 4'd0, 11'd0, 1'b1, {48'd0, 31'd1073741824, 15'd16384, 15'd16384, 1'b0}},
      {HUGE_RGBA, 4'd14, 11'd2047, 1'b0, ZERO_RSP},
      {HUGE_RGBA, 4'd15, 11'd0, 1'b1, FAULT_RSP},
      {HUGE_RGBA, 4'd0, 11'd2047, 1'b0, ZERO_RSP},
      {OVER_RGB, 4'd0, 11'd0, 1'b1, {48'd0, 31'h7FFF_FFFF, 15'd32767, 15'd32767, 1'b0}},
      {OVER_RGB, 4'd0, 11'd2047, 1'b0, ZERO_RSP},
      {OVER_RGB, 4'd3, 11'd2047, 1'b0, ZERO_RSP},
      {{FMT_UNKNOWN_LAST, 15'd100, 15'd60, 4'd8, 12'd3}, 4'd5, 11'd2, 1'b1,
       {48'd0, 31'd0, 15'd3, 15'd1, 1'b0}},
      {{FMT_DXT1, 15'd0, 15'd0, 4'd0, 12'd0}, 4'd0, 11'd0, 1'b1, FAULT_RSP},
      {EMPTY_ONE, 4'd0, 11'd4, 1'b1, ZERO_RSP},
      {EMPTY_ONE, 4'd1, 11'd0, 1'b1, FAULT_RSP},
      {EMPTY_MIP, 4'd1, 11'd4, 1'b1, {48'd64, 31'd8, 15'd1, 15'd1, 1'b0}},
      {EMPTY_MIP, 4'd0, 11'd5, 1'b1, FAULT_RSP},
      {{FMT_DXT3, 15'd37, 15'd19, 4'd6, 12'd9}, 4'd3, 11'd8, 1'b0, ZERO_RSP},
      {{FMT_DXT5, 15'd37, 15'd19, 4'd6, 12'd9}, 4'd5, 11'd0, 1'b0, ZERO_RSP},
      {{FMT_ATI1, 15'd37, 15'd19, 4'd6, 12'd9}, 4'd0, 11'd8, 1'b0, ZERO_RSP},
      {{FMT_ATI2, 15'd37, 15'd19, 4'd6, 12'd9}, 4'd2, 11'd3, 1'b0, ZERO_RSP},
      {{FMT_BPTC_A, 15'd37, 15'd19, 4'd6, 12'd9}, 4'd4, 11'd7, 1'b0, ZERO_RSP},
      {{FMT_BPTC_B, 15'd37, 15'd19, 4'd6, 12'd9}, 4'd1, 11'd1, 1'b0, ZERO_RSP},
      {{FMT_UNKNOWN_FIRST, 15'd37, 15'd19, 4'd6, 12'd9}, 4'd0, 11'd0, 1'b1,
       {48'd0, 31'd0, 15'd37, 15'd19, 1'b0}}
   };

   mip_level_offset_calculator uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap(input bit on);
      int r;
      if (!on) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [63:0] halve_dim(input logic [63:0] d);
      return (d / 2 < 1) ? 64'd1 : d / 2;
   endfunction

   function automatic logic [63:0] block_count(input logic [63:0] w, input logic [63:0] h);
      return ((w + 3) / 4) * ((h + 3) / 4);
   endfunction

   function automatic rsp_payload_type locate_level(input store_cfg_type c,
                                                    input req_payload_type r);
      rsp_payload_type o;
      logic [63:0] nlev, nimg, bpb, w, h, image_bytes, offset, size;
      int i;
      o = '0;
      nlev = (c.levels == 0) ? 64'd1 : 64'(c.levels);
      if (nlev > 64'(MAX_LEVELS)) begin
         nlev = 64'(MAX_LEVELS);
      end
      nimg = (c.images > MAX_IMAGES) ? 64'(MAX_IMAGES) : 64'(c.images);
      if (r.level_index >= nlev || r.image_select >= nimg) begin
         o.index_error = 1'b1;
         return o;
      end
      case (c.fmt) inside
         FMT_DXT1, FMT_ATI1: bpb = 64'd8;
         FMT_DXT3, FMT_DXT5, FMT_ATI2, FMT_BPTC_A, FMT_BPTC_B: bpb = 64'd16;
         FMT_BGR: bpb = 64'd48;
         FMT_BGRA: bpb = 64'd64;
         default: bpb = 64'd0;
      endcase
      w = 64'(c.width);
      h = 64'(c.height);
      image_bytes = '0;
      for (i = 0; i < nlev; i++) begin
         image_bytes += block_count(w, h) * bpb;
         w = halve_dim(w);
         h = halve_dim(h);
      end
      w = 64'(c.width);
      h = 64'(c.height);
      offset = 64'(r.image_select) * image_bytes;
      size = block_count(w, h) * bpb;
      for (i = 0; i < r.level_index; i++) begin
         offset += size;
         w = halve_dim(w);
         h = halve_dim(h);
         size = block_count(w, h) * bpb;
      end
      o.byte_offset  = offset[OFF_W-1:0];
      o.byte_size    = (size > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : size[BYTES_W-1:0];
      o.level_width  = w[DIM_W-1:0];
      o.level_height = h[DIM_W-1:0];
      return o;
   endfunction

   function automatic logic [14:0] pick_dim();
      case ($urandom_range(0, 7))
         0: return 15'd0;
         1: return 15'd16384;
         2: return 15'd32767;
         3: return 15'($urandom_range(1, 8));
         4: return 15'($urandom_range(0, 32767));
         default: return 15'($urandom_range(1, 16384));
      endcase
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= 40) begin
         $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
                  $realtime, results_seen, field, got, want);
      end
   endtask

   task automatic check_result(input rsp_payload_type got);
      rsp_payload_type want;
      results_seen++;
      if (expected_levels.size() == 0) begin
         report_mismatch("arrived with no request outstanding", 64'(got.byte_offset),
                         64'd0);
         return;
      end
      want = expected_levels.pop_front();
      if (got.byte_offset !== want.byte_offset) begin
         report_mismatch("byte_offset", 64'(got.byte_offset), 64'(want.byte_offset));
      end
      if (got.byte_size !== want.byte_size) begin
         report_mismatch("byte_size", 64'(got.byte_size), 64'(want.byte_size));
      end
      if (got.level_width !== want.level_width) begin
         report_mismatch("level_width", 64'(got.level_width), 64'(want.level_width));
      end
      if (got.level_height !== want.level_height) begin
         report_mismatch("level_height", 64'(got.level_height), 64'(want.level_height));
      end
      if (got.index_error !== want.index_error) begin
         report_mismatch("index_error", 64'(got.index_error), 64'(want.index_error));
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_payload);
         end
         if (req_valid && !req_ready) begin
            stalled_cycles++;
         end
      end
      if (hold_rsp) begin
         rsp_ready <= 1'b0;
      end else if (rsp_gap_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_gap_left <= rsp_gap_left - 1;
      end else begin
         rsp_gap_draw = pick_gap(rsp_idle_on);
         if (rsp_gap_draw == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            rsp_gap_left <= rsp_gap_draw - 1;
         end
      end
   end

   // Long receiver stall while the sender keeps offering, so the pipeline fills.
   initial begin
      wait (hold_off_armed);
      repeat (4) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_FORMAT: store_regs.fmt    = data[3:0];
         CSR_WIDTH:  store_regs.width  = data[14:0];
         CSR_HEIGHT: store_regs.height = data[14:0];
         CSR_LEVELS: store_regs.levels = data[3:0];
         CSR_IMAGES: store_regs.images = data[11:0];
         default: ;
      endcase
   endtask

   task automatic program_store(input store_cfg_type c, input bit junk_on);
      logic [15:0] junk;
      req_valid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      junk = junk_on ? 16'($urandom) : 16'd0;
      if (junk_on) begin
         write_reg(3'($urandom_range(CSR_FIRST_UNUSED, CSR_LAST_UNUSED)), 16'($urandom));
      end
      write_reg(CSR_FORMAT, {junk[11:0], c.fmt});
      write_reg(CSR_WIDTH,  {junk[12], c.width});
      write_reg(CSR_HEIGHT, {junk[13], c.height});
      write_reg(CSR_LEVELS, {junk[11:0], c.levels});
      write_reg(CSR_IMAGES, {junk[3:0], c.images});
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic send_request(input req_payload_type r, input bit given,
                               input rsp_payload_type given_rsp);
      int gap;
      rsp_payload_type want;
      gap = pick_gap(req_idle_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = given ? given_rsp : locate_level(store_regs, r);
      expected_levels.push_back(want);
      requests_sent++;
      if (want.index_error) begin
         index_faults++;
      end
      if (want.byte_size == 31'h7FFF_FFFF) begin
         saturated_sizes++;
      end
   endtask

   initial begin
      req_payload_type req;
      store_cfg_type cfg;
      int i, phase, n, nlev, nimg;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < PROBE_COUNT; i++) begin
         if (probes[i].cfg != store_regs) begin
            program_store(probes[i].cfg, 1'b0);
         end
         req.level_index  = probes[i].level;
         req.image_select = probes[i].image;
         send_request(req, probes[i].known, probes[i].want);
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if ($urandom_range(0, 9) == 0) begin
            cfg.fmt = 4'($urandom_range(FMT_UNKNOWN_FIRST, FMT_UNKNOWN_LAST));
         end else begin
            cfg.fmt = 4'($urandom_range(FMT_DXT1, FMT_BPTC_B));
         end
         cfg.width  = pick_dim();
         cfg.height = pick_dim();
         cfg.levels = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
         case ($urandom_range(0, 9))
            0: cfg.images = 12'd0;
            1: cfg.images = 12'($urandom_range(MAX_IMAGES + 1, 4095));
            2: cfg.images = 12'(MAX_IMAGES);
            3, 4, 5: cfg.images = 12'($urandom_range(1, 8));
            default: cfg.images = 12'($urandom_range(1, MAX_IMAGES));
         endcase
         program_store(cfg, 1'b1);
         req_idle_on = (phase > 1) && ($urandom_range(0, 3) != 0);
         rsp_idle_on = (phase != 1) && ($urandom_range(0, 3) != 0);
         if (phase == 0) begin
            hold_off_armed = 1'b1;
         end
         nlev = (store_regs.levels == 0) ? 1 : int'(store_regs.levels);
         nimg = (store_regs.images > MAX_IMAGES) ? MAX_IMAGES : int'(store_regs.images);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (nimg != 0 && $urandom_range(0, 99) < 85) begin
               req.level_index  = 4'($urandom_range(0, nlev - 1));
               req.image_select = 11'($urandom_range(0, nimg - 1));
            end else begin
               req.level_index  = 4'($urandom);
               req.image_select = 11'($urandom);
            end
            send_request(req, 1'b0, ZERO_RSP);
         end
      end
      req_valid <= 1'b0;

      while (expected_levels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Covered %0d requests over %0d register settings, %0d index errors,",
               requests_sent, settings_used, index_faults);
      $display("%0d saturated sizes; requests stalled by back-pressure for %0d cycles.",
               saturated_sizes, stalled_cycles);
      if (mismatches == 0) begin
         $display("mip_level_offset_calculator test passed");
      end else begin
         $display("mip_level_offset_calculator test failed");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Timed out with %0d results outstanding.", expected_levels.size());
      $display("mip_level_offset_calculator test failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/mip_off_pkg.sv
rtl/mip_level_offset_calculator.sv
tb/sv/tb_top.sv
